[design/assert_macros.svh]
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked on clk_i, switched off while rst_ni is low
`define HSV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked on clk_i, also checked during reset
`define HSV_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/hsv_pkg.sv]
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int DATA_W        = 16;
  localparam int FRAC_BITS_DEF = 12;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_e;

  typedef struct packed {
    logic    grey;
    sector_e sec;
  } ctrl_t;

endpackage

[design/hsv_to_rgb.sv]
// An accepted request passes the register stages listed below to out_valid_o, and is held while out_stall_i holds.
// Throughput: one request per cycle while out_stall_i is low; five register stages (clamp and sector split,
// first products, one minus terms, second products, formula select and saturation).
// Reset (rst_ni low, asynchronous): all stage valids clear and unbounded mode is off.
// cfg_ready_o is always high; the mode bit is taken on cfg_valid_i.
`timescale 1ns / 1ps

module hsv_to_rgb #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [hsv_pkg::DATA_W-1:0] hue_i,
  input  logic signed [hsv_pkg::DATA_W-1:0] saturation_i,
  input  logic signed [hsv_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [hsv_pkg::DATA_W-1:0] red_o,
  output logic signed [hsv_pkg::DATA_W-1:0] green_o,
  output logic signed [hsv_pkg::DATA_W-1:0] blue_o
);
  import hsv_pkg::*;

  localparam int OW = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int MW = DATA_W + OW;
  localparam int RW = MW - FRAC_BITS;

  logic unbounded_q, unbounded_d;

  logic                     prep_ready, prep_valid;
  ctrl_t                    prep_ctrl;
  logic signed [DATA_W-1:0] prep_s, prep_v;
  logic [FRAC_BITS-1:0]     prep_f;
  logic [FRAC_BITS:0]       prep_omf;
  logic signed [OW-1:0]     prep_oms;

  logic                     mul_ready, mul_valid;
  ctrl_t                    mul_ctrl;
  logic signed [DATA_W-1:0] mul_v;
  logic signed [RW-1:0]     mul_m;
  logic signed [MW-1:0]     mul_pn, mul_pk;

  logic                     mix_ready;

  assign cfg_ready_o = 1'b1;
  assign unbounded_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : unbounded_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unbounded_q <= 1'b0;
    end else begin
      unbounded_q <= unbounded_d;
    end
  end

  assign in_stall_o = !prep_ready;

  hsv_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .unbounded_i (unbounded_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (prep_ready),
    .hue_i       (hue_i),
    .sat_i       (saturation_i),
    .val_i       (value_i),
    .out_valid_o (prep_valid),
    .out_ready_i (mul_ready),
    .ctrl_o      (prep_ctrl),
    .s_o         (prep_s),
    .v_o         (prep_v),
    .f_o         (prep_f),
    .omf_o       (prep_omf),
    .oms_o       (prep_oms)
  );

  hsv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (mul_ready),
    .ctrl_i      (prep_ctrl),
    .s_i         (prep_s),
    .v_i         (prep_v),
    .f_i         (prep_f),
    .omf_i       (prep_omf),
    .oms_i       (prep_oms),
    .out_valid_o (mul_valid),
    .out_ready_i (mix_ready),
    .ctrl_o      (mul_ctrl),
    .v_o         (mul_v),
    .m_o         (mul_m),
    .pn_o        (mul_pn),
    .pk_o        (mul_pk)
  );

  hsv_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mix_ready),
    .ctrl_i      (mul_ctrl),
    .v_i         (mul_v),
    .m_i         (mul_m),
    .pn_i        (mul_pn),
    .pk_i        (mul_pk),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

endmodule

[design/hsv_prep.sv]
`timescale 1ns / 1ps

module hsv_prep #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF,
  localparam int OW = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 unbounded_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [hsv_pkg::DATA_W-1:0]    hue_i,
  input  logic signed [hsv_pkg::DATA_W-1:0]    sat_i,
  input  logic signed [hsv_pkg::DATA_W-1:0]    val_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output hsv_pkg::ctrl_t                       ctrl_o,
  output logic signed [hsv_pkg::DATA_W-1:0]    s_o,
  output logic signed [hsv_pkg::DATA_W-1:0]    v_o,
  output logic        [FRAC_BITS-1:0]          f_o,
  output logic        [FRAC_BITS:0]            omf_o,
  output logic signed [OW-1:0]                 oms_o
);
  import hsv_pkg::*;

  localparam int CW  = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
  localparam int H6W = (FRAC_BITS + 4 > 19) ? FRAC_BITS + 4 : 19;
  localparam int FW1 = FRAC_BITS + 1;
  localparam logic signed [CW-1:0] ONE_C = CW'(longint'(1) << FRAC_BITS);

  function automatic logic signed [DATA_W-1:0] clamp01(input logic signed [DATA_W-1:0] x);
    logic signed [CW-1:0] xe;
    xe = CW'(x);
    if (xe < 0) begin
      return '0;
    end else if (xe > ONE_C) begin
      return DATA_W'(ONE_C);
    end else begin
      return x;
    end
  endfunction

  logic signed [DATA_W-1:0] h, s, v;
  logic signed [H6W-1:0]    h6, sec_w;
  logic        [FRAC_BITS-1:0] f;
  logic        [FRAC_BITS:0]   omf;
  logic signed [OW-1:0]     oms;
  ctrl_t                    ctrl;
  logic                     en;
  logic                     vld_q;

  ctrl_t                    ctrl_q;
  logic signed [DATA_W-1:0] s_q, v_q;
  logic        [FRAC_BITS-1:0] f_q;
  logic        [FRAC_BITS:0]   omf_q;
  logic signed [OW-1:0]     oms_q;

  always_comb begin
    h     = unbounded_i ? hue_i : clamp01(hue_i);
    s     = unbounded_i ? sat_i : clamp01(sat_i);
    v     = unbounded_i ? val_i : clamp01(val_i);
    h6    = H6W'(h) * H6W'(6);
    sec_w = h6 >>> FRAC_BITS;
    f     = h6[FRAC_BITS-1:0];
    omf   = FW1'(ONE_C) - {1'b0, f};
    oms   = OW'(ONE_C) - OW'(s);
    ctrl.grey = (s == '0);
    case (sec_w)
      H6W'(0), H6W'(6): ctrl.sec = SEC_0;
      H6W'(1):          ctrl.sec = SEC_1;
      H6W'(2):          ctrl.sec = SEC_2;
      H6W'(3):          ctrl.sec = SEC_3;
      H6W'(4):          ctrl.sec = SEC_4;
      default:          ctrl.sec = SEC_5;
    endcase
  end

  assign en         = !vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctrl_q <= ctrl;
      s_q    <= s;
      v_q    <= v;
      f_q    <= f;
      omf_q  <= omf;
      oms_q  <= oms;
    end
  end

  assign out_valid_o = vld_q;
  assign ctrl_o      = ctrl_q;
  assign s_o         = s_q;
  assign v_o         = v_q;
  assign f_o         = f_q;
  assign omf_o       = omf_q;
  assign oms_o       = oms_q;

endmodule

[design/hsv_mul.sv]
`timescale 1ns / 1ps

module hsv_mul #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF,
  localparam int OW = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18,
  localparam int MW = hsv_pkg::DATA_W + OW,
  localparam int RW = MW - FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hsv_pkg::ctrl_t                    ctrl_i,
  input  logic signed [hsv_pkg::DATA_W-1:0] s_i,
  input  logic signed [hsv_pkg::DATA_W-1:0] v_i,
  input  logic        [FRAC_BITS-1:0]       f_i,
  input  logic        [FRAC_BITS:0]         omf_i,
  input  logic signed [OW-1:0]              oms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hsv_pkg::ctrl_t                    ctrl_o,
  output logic signed [hsv_pkg::DATA_W-1:0] v_o,
  output logic signed [RW-1:0]              m_o,
  output logic signed [MW-1:0]              pn_o,
  output logic signed [MW-1:0]              pk_o
);
  import hsv_pkg::*;

  localparam int PFW = DATA_W + FRAC_BITS + 1;
  localparam int PKW = DATA_W + FRAC_BITS + 2;
  localparam logic signed [OW-1:0] ONE_W = OW'(longint'(1) << FRAC_BITS);

  logic en_a, en_b, en_c;
  logic vld_a_q, vld_b_q, vld_c_q;

  // stage a: s*f, s*(1-f), v*(1-s)
  logic signed [PFW-1:0]    psf;
  logic signed [PKW-1:0]    psk;
  logic signed [MW-1:0]     pm;
  logic signed [PFW-1:0]    psf_q;
  logic signed [PKW-1:0]    psk_q;
  logic signed [MW-1:0]     pm_q;
  logic signed [DATA_W-1:0] v_a_q;
  ctrl_t                    ctrl_a_q;

  // stage b: 1 - s*f, 1 - s*(1-f), m
  logic signed [OW-1:0]     an, ak;
  logic signed [RW-1:0]     m_b;
  logic signed [OW-1:0]     an_q, ak_q;
  logic signed [RW-1:0]     m_b_q;
  logic signed [DATA_W-1:0] v_b_q;
  ctrl_t                    ctrl_b_q;

  // stage c: v*(1 - s*f), v*(1 - s*(1-f))
  logic signed [MW-1:0]     pn, pk;
  logic signed [MW-1:0]     pn_q, pk_q;
  logic signed [RW-1:0]     m_c_q;
  logic signed [DATA_W-1:0] v_c_q;
  ctrl_t                    ctrl_c_q;

  assign en_c       = !vld_c_q || out_ready_i;
  assign en_b       = !vld_b_q || en_c;
  assign en_a       = !vld_a_q || en_b;
  assign in_ready_o = en_a;

  assign psf = PFW'(s_i) * PFW'($signed({1'b0, f_i}));
  assign psk = PKW'(s_i) * PKW'($signed({1'b0, omf_i}));
  assign pm  = MW'(v_i) * MW'(oms_i);

  assign an  = ONE_W - OW'(psf_q >>> FRAC_BITS);
  assign ak  = ONE_W - OW'(psk_q >>> FRAC_BITS);
  assign m_b = RW'(pm_q >>> FRAC_BITS);

  assign pn = MW'(v_b_q) * MW'(an_q);
  assign pk = MW'(v_b_q) * MW'(ak_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (en_a) begin
        vld_a_q <= in_valid_i;
      end
      if (en_b) begin
        vld_b_q <= vld_a_q;
      end
      if (en_c) begin
        vld_c_q <= vld_b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      psf_q    <= psf;
      psk_q    <= psk;
      pm_q     <= pm;
      v_a_q    <= v_i;
      ctrl_a_q <= ctrl_i;
    end
    if (en_b) begin
      an_q     <= an;
      ak_q     <= ak;
      m_b_q    <= m_b;
      v_b_q    <= v_a_q;
      ctrl_b_q <= ctrl_a_q;
    end
    if (en_c) begin
      pn_q     <= pn;
      pk_q     <= pk;
      m_c_q    <= m_b_q;
      v_c_q    <= v_b_q;
      ctrl_c_q <= ctrl_b_q;
    end
  end

  assign out_valid_o = vld_c_q;
  assign ctrl_o      = ctrl_c_q;
  assign v_o         = v_c_q;
  assign m_o         = m_c_q;
  assign pn_o        = pn_q;
  assign pk_o        = pk_q;

endmodule

[design/hsv_mix.sv]
`timescale 1ns / 1ps

module hsv_mix #(
  parameter int FRAC_BITS = hsv_pkg::FRAC_BITS_DEF,
  localparam int OW = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18,
  localparam int MW = hsv_pkg::DATA_W + OW,
  localparam int RW = MW - FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hsv_pkg::ctrl_t                    ctrl_i,
  input  logic signed [hsv_pkg::DATA_W-1:0] v_i,
  input  logic signed [RW-1:0]              m_i,
  input  logic signed [MW-1:0]              pn_i,
  input  logic signed [MW-1:0]              pk_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hsv_pkg::DATA_W-1:0] red_o,
  output logic signed [hsv_pkg::DATA_W-1:0] green_o,
  output logic signed [hsv_pkg::DATA_W-1:0] blue_o
);
  import hsv_pkg::*;

  localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [RW-1:0] x);
    if (x > SAT_HI) begin
      return DATA_W'(SAT_HI);
    end else if (x < SAT_LO) begin
      return DATA_W'(SAT_LO);
    end else begin
      return DATA_W'(x);
    end
  endfunction

  logic signed [RW-1:0]     n, k, ve, r, g, b;
  logic                     en;
  logic                     vld_q;
  logic signed [DATA_W-1:0] red_q, green_q, blue_q;

  always_comb begin
    n  = RW'(pn_i >>> FRAC_BITS);
    k  = RW'(pk_i >>> FRAC_BITS);
    ve = RW'(v_i);
    if (ctrl_i.grey) begin
      r = ve; g = ve; b = ve;
    end else begin
      case (ctrl_i.sec)
        SEC_0: begin r = ve;  g = k;   b = m_i; end
        SEC_1: begin r = n;   g = ve;  b = m_i; end
        SEC_2: begin r = m_i; g = ve;  b = k;   end
        SEC_3: begin r = m_i; g = n;   b = ve;  end
        SEC_4: begin r = k;   g = m_i; b = ve;  end
        default: begin r = ve; g = m_i; b = n; end
      endcase
    end
  end

  assign en         = !vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= sat16(r);
      green_q <= sat16(g);
      blue_q  <= sat16(b);
    end
  end

  assign out_valid_o = vld_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

[design/hsv_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic                              cfg_data_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic signed [hsv_pkg::DATA_W-1:0] hue_i,
  input logic signed [hsv_pkg::DATA_W-1:0] saturation_i,
  input logic signed [hsv_pkg::DATA_W-1:0] value_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [hsv_pkg::DATA_W-1:0] red_o,
  input logic signed [hsv_pkg::DATA_W-1:0] green_o,
  input logic signed [hsv_pkg::DATA_W-1:0] blue_o
);

  // input only backs up when the whole pipe is full behind a stalled output
  `HSV_ASSERT(a_stall_only_when_full, in_stall_o |-> out_valid_o && out_stall_i,
              "input stalled with room in pipe")

  // a request taken into an unstalled pipe comes out at out_valid_o
  `HSV_ASSERT(a_latency, (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i
              ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o,
              "request lost in pipe")

  `HSV_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o)
              && $stable(green_o) && $stable(blue_o), "stalled result changed")

  `HSV_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o, "result shown in reset")

endmodule

bind hsv_to_rgb hsv_chk u_hsv_chk (.*);
